[rtl/assert_macros.svh]
// Assertion macros used by the checker module of the search engine.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OWRSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("search engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define OWRSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("search engine check failed");

`endif

[rtl/owrse_pkg.sv]
// Shared constants, codes and structs of the 1-Wire ROM search engine.
// Has no dependencies; the decide, top-level and checker files refer to it by scoped names.
package owrse_pkg;

    // Sizes of the stack, the ID and the counters.
    localparam int STACK_DEPTH   = 64;
    localparam int STACK_ENTRIES = STACK_DEPTH + 1;
    localparam int LEVEL_W       = $clog2(STACK_ENTRIES);
    localparam int ID_BITS       = 64;
    localparam int POS_W         = $clog2(ID_BITS);
    localparam int CPOS_W        = POS_W + 1;
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = POS_W - 3;
    localparam int COUNT_W       = 8;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = LEVEL_W'(STACK_DEPTH);
    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [POS_W-1:0]   POS_LAST    = '1;
    localparam logic [2:0]         BYTE_LAST   = 3'b111;

    // Register index, taken from the word address bit.
    localparam logic REG_DEVICE_LIMIT = 1'b0;

    // Operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_PAIR  = 1'b1;

    // Bit pair codes, ID bit first.
    localparam logic [1:0] PAIR_CONFLICT = 2'b00;
    localparam logic [1:0] PAIR_ZERO     = 2'b01;
    localparam logic [1:0] PAIR_ONE      = 2'b10;
    localparam logic [1:0] PAIR_NONE     = 2'b11;

    // Register-held search state.
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   pos;
        logic [BYTE_W-1:0]  shift;
        logic [COUNT_W-1:0] found;
        logic               searching;
    } search_state_t;

    // One result beat.
    typedef struct packed {
        logic               write_valid;
        logic               write_bit;
        logic               byte_valid;
        logic [BYTE_W-1:0]  id_byte;
        logic [IDX_W-1:0]   byte_index;
        logic [COUNT_W-1:0] device_index;
        logic               pass_done;
        logic               search_done;
        logic [COUNT_W-1:0] device_count;
    } result_t;

    // Write-back to the stack and path memories.
    typedef struct packed {
        logic               stack_we;
        logic [LEVEL_W-1:0] stack_addr;
        logic [CPOS_W-1:0]  stack_data;
        logic               path_we;
        logic [POS_W-1:0]   path_addr;
        logic               path_data;
    } mem_wr_t;

endpackage

[rtl/owrse_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the conflict stack and the path bits.
module owrse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/owrse_decide.sv]
// Search decision for one beat: start, direction bit, stack update, byte assembly, pass end.
// Depends on owrse_pkg for the state, result and write-back structs.
module owrse_decide (
    input  owrse_pkg::search_state_t          st,
    input  logic [owrse_pkg::CPOS_W-1:0]      top_entry,
    input  logic                              path_bit,
    input  logic                              operation,
    input  logic                              id_bit,
    input  logic                              complement_bit,
    input  logic [owrse_pkg::COUNT_W-1:0]     device_limit,
    output owrse_pkg::search_state_t          st_next,
    output owrse_pkg::result_t                res,
    output owrse_pkg::mem_wr_t                wr
);

    logic [owrse_pkg::CPOS_W-1:0]  cpos;
    logic [owrse_pkg::CPOS_W-1:0]  top;
    logic [1:0]                    pair;
    logic                          wv;
    logic                          wb;
    logic [owrse_pkg::BYTE_W-1:0]  shifted;
    logic [owrse_pkg::COUNT_W-1:0] found_inc;

    always_comb
    begin
        st_next       = st;
        res           = '0;
        wr            = '0;
        wr.path_addr  = st.pos;
        wr.stack_addr = st.level + owrse_pkg::LEVEL_W'(1);
        // The bottom entry is the zero sentinel and is never stored.
        cpos          = owrse_pkg::CPOS_W'(st.pos) + owrse_pkg::CPOS_W'(1);
        top           = (st.level == '0) ? '0 : top_entry;
        pair          = {id_bit, complement_bit};
        wv            = 1'b0;
        wb            = 1'b0;
        shifted       = '0;
        found_inc     = (st.found != owrse_pkg::COUNT_MAX) ?
                        st.found + owrse_pkg::COUNT_W'(1) : st.found;

        if (operation == owrse_pkg::OP_START)
        begin
            // A new search clears everything but the device limit.
            st_next           = '0;
            st_next.searching = 1'b1;
        end
        else if (!st.searching)
        begin
            res.device_count = st.found;
        end
        else
        begin
            // Direction choice and stack maintenance.
            unique case (pair)
                owrse_pkg::PAIR_ZERO:
                begin
                    wv           = 1'b1;
                    wb           = 1'b0;
                    wr.path_we   = 1'b1;
                    wr.path_data = 1'b0;
                end
                owrse_pkg::PAIR_ONE:
                begin
                    wv           = 1'b1;
                    wb           = 1'b1;
                    wr.path_we   = 1'b1;
                    wr.path_data = 1'b1;
                end
                owrse_pkg::PAIR_CONFLICT:
                begin
                    wv = 1'b1;
                    priority if (cpos > top)
                    begin
                        // New conflict: take the zero branch and remember it.
                        wb           = 1'b0;
                        wr.path_we   = 1'b1;
                        wr.path_data = 1'b0;
                        if (st.level < owrse_pkg::LEVEL_FULL)
                        begin
                            st_next.level = st.level + owrse_pkg::LEVEL_W'(1);
                            wr.stack_we   = 1'b1;
                            wr.stack_data = cpos;
                        end
                    end
                    else if (cpos < top)
                    begin
                        wb = path_bit;
                    end
                    else
                    begin
                        // Last open conflict: take the one branch now.
                        wb           = 1'b1;
                        wr.path_we   = 1'b1;
                        wr.path_data = 1'b1;
                        if (st.level != '0)
                        begin
                            st_next.level = st.level - owrse_pkg::LEVEL_W'(1);
                        end
                    end
                end
                owrse_pkg::PAIR_NONE:
                begin
                    wv = 1'b0;
                end
            endcase

            // Byte assembly, LSB first.
            shifted           = {wb, st.shift[owrse_pkg::BYTE_W-1:1]};
            st_next.shift     = shifted;
            res.write_valid   = wv;
            res.write_bit     = wb;
            res.device_index  = st.found;
            if (st.pos[2:0] == owrse_pkg::BYTE_LAST)
            begin
                res.byte_valid = 1'b1;
                res.id_byte    = shifted;
                res.byte_index = st.pos[owrse_pkg::POS_W-1:3];
                st_next.shift  = '0;
            end

            // End of pass and end of search.
            st_next.pos = st.pos + owrse_pkg::POS_W'(1);
            if (st.pos == owrse_pkg::POS_LAST)
            begin
                res.pass_done = 1'b1;
                st_next.found = found_inc;
                if (st_next.level == '0 || found_inc >= device_limit)
                begin
                    res.search_done   = 1'b1;
                    st_next.searching = 1'b0;
                end
            end
            res.device_count = st_next.found;
        end
    end

endmodule

[rtl/onewire_rom_search_engine_unit.sv]
// 1-Wire ROM search engine, top level: one bit pair in, one result beat out.
// An accepted bit pair waits in the decision stage registers, then its result beat
// in the result registers; no new pair is taken while that stage holds one, for the
// read-then-write of the conflict stack and path memories for each bit pair.
// Reset clears the search state and sets device_limit to 8; the memories are
// not cleared and need no clearing pass.
module onewire_rom_search_engine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [owrse_pkg::PADDR_W-1:0]     paddr,
    input  logic [owrse_pkg::PDATA_W-1:0]     pwdata,
    output logic [owrse_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic                              id_bit,
    input  logic                              complement_bit,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              write_valid,
    output logic                              write_bit,
    output logic                              byte_valid,
    output logic [owrse_pkg::BYTE_W-1:0]      id_byte,
    output logic [owrse_pkg::IDX_W-1:0]       byte_index,
    output logic [owrse_pkg::COUNT_W-1:0]     device_index,
    output logic                              pass_done,
    output logic                              search_done,
    output logic [owrse_pkg::COUNT_W-1:0]     device_count
);

    owrse_pkg::search_state_t      st_reg;
    owrse_pkg::search_state_t      st_next;
    owrse_pkg::search_state_t      st_calc;
    owrse_pkg::result_t            res_calc;
    owrse_pkg::result_t            res_reg;
    owrse_pkg::mem_wr_t            wr;
    logic [owrse_pkg::COUNT_W-1:0] limit_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_op_reg;
    logic                          s1_id_reg;
    logic                          s1_cmp_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          in_fire;
    logic                          s1_done;
    logic                          cfg_write;
    logic [owrse_pkg::CPOS_W-1:0]  top_entry;
    logic                          path_bit;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == owrse_pkg::REG_DEVICE_LIMIT) ?
                       owrse_pkg::PDATA_W'(limit_reg) : '0;

    // Handshake: the decision stage holds one beat while its memories are read.
    assign in_stall = s1_valid_reg;
    assign in_fire  = in_valid & ~s1_valid_reg;
    assign s1_done  = s1_valid_reg & (~out_valid_reg | ~out_stall);

    always_comb
    begin
        s1_valid_next  = in_fire | (s1_valid_reg & ~s1_done);
        out_valid_next = s1_done | (out_valid_reg & out_stall);
        st_next        = s1_done ? st_calc : st_reg;
    end

    // Conflict stack: read at the current level, pushed by the decision stage.
    owrse_ram #(
        .WIDTH (owrse_pkg::CPOS_W),
        .DEPTH (owrse_pkg::STACK_ENTRIES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (wr.stack_we & s1_done),
        .waddr (wr.stack_addr),
        .wdata (wr.stack_data),
        .raddr (st_reg.level),
        .rdata (top_entry)
    );

    // Path bits of the last pass, one per bit position.
    owrse_ram #(
        .WIDTH (1),
        .DEPTH (owrse_pkg::ID_BITS)
    ) u_path_ram (
        .clk   (clk),
        .we    (wr.path_we & s1_done),
        .waddr (wr.path_addr),
        .wdata (wr.path_data),
        .raddr (st_reg.pos),
        .rdata (path_bit)
    );

    // Decision logic.
    owrse_decide u_decide (
        .st             (st_reg),
        .top_entry      (top_entry),
        .path_bit       (path_bit),
        .operation      (s1_op_reg),
        .id_bit         (s1_id_reg),
        .complement_bit (s1_cmp_reg),
        .device_limit   (limit_reg),
        .st_next        (st_calc),
        .res            (res_calc),
        .wr             (wr)
    );

    // Control state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= owrse_pkg::LIMIT_RESET;
        end
        else
        begin
            st_reg        <= st_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && paddr[2] == owrse_pkg::REG_DEVICE_LIMIT)
            begin
                limit_reg <= pwdata[owrse_pkg::COUNT_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg  <= operation;
            s1_id_reg  <= id_bit;
            s1_cmp_reg <= complement_bit;
        end
        if (s1_done)
        begin
            res_reg <= res_calc;
        end
    end

    // Result beat.
    assign out_valid    = out_valid_reg;
    assign write_valid  = res_reg.write_valid;
    assign write_bit    = res_reg.write_bit;
    assign byte_valid   = res_reg.byte_valid;
    assign id_byte      = res_reg.id_byte;
    assign byte_index   = res_reg.byte_index;
    assign device_index = res_reg.device_index;
    assign pass_done    = res_reg.pass_done;
    assign search_done  = res_reg.search_done;
    assign device_count = res_reg.device_count;

endmodule

[rtl/owrse_checker.sv]
// Port-level checks of the search engine, bound to the top level.
// Depends on owrse_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module owrse_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          write_valid,
    input logic                          write_bit,
    input logic                          byte_valid,
    input logic [owrse_pkg::BYTE_W-1:0]  id_byte,
    input logic [owrse_pkg::IDX_W-1:0]   byte_index,
    input logic                          pass_done,
    input logic                          search_done
);

    // A beat accepted now keeps the input stalled for the following cycle.
    `OWRSE_ASSERT_NEXT(a_accept_interlock, in_valid && !in_stall, in_stall)

    // No direction bit is shown without a bus write.
    `OWRSE_ASSERT_NOW(a_bit_needs_write, out_valid && !write_valid, !write_bit)

    // Byte fields stay zero unless a byte is complete.
    `OWRSE_ASSERT_NOW(a_byte_quiet, out_valid && !byte_valid, id_byte == '0 && byte_index == '0)

    // The search only ends on the last bit of a pass.
    `OWRSE_ASSERT_NOW(a_done_on_pass, out_valid && search_done, pass_done)

    // A stalled result beat stays offered.
    `OWRSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind onewire_rom_search_engine_unit owrse_checker u_owrse_checker (.*);
